// ----- sv/mlo_pkg.sv -----
// ----------------------------------------------------------------------------
// mlo_pkg
// Types and helpers shared by the mipmap layout offset calculator.
// ----------------------------------------------------------------------------
package mlo_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // largest base width and height; the field widths below are sized for it
  localparam int unsigned MaxDim   = 4096;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_MODE  = 3'd0,
    REG_COMPRESSED   = 3'd1,
    REG_BASE_WIDTH   = 3'd2,
    REG_BASE_HEIGHT  = 3'd3,
    REG_BASE_DEPTH   = 3'd4,
    REG_FINAL_LEVEL  = 3'd5,
    REG_BLOCK_BYTES  = 3'd6,
    REG_BLOCK_DIM    = 3'd7
  } cfg_reg_e;

  localparam logic [1:0] TARGET_CUBE   = 2'd1;
  localparam logic [1:0] TARGET_VOLUME = 2'd2;
  localparam logic [3:0] CUBE_FACES    = 4'd6;

  typedef struct packed {
    logic [3:0]  query_level;
    logic [10:0] image_index;
  } query_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic [12:0] level_width;
    logic [12:0] level_height;
    logic [11:0] level_depth;
    logic [12:0] level_blocks_x;
    logic [12:0] level_blocks_y;
    logic [16:0] row_stride_bytes;
    logic [15:0] total_block_rows;
    logic        query_error;
  } result_t;

  // static texture description seen by every cell
  typedef struct packed {
    logic       packed_mode;   // cube or volume
    logic       volume;
    logic       compressed;
    logic [1:0] blk_sh;
    logic [3:0] last;
  } cell_cfg_t;

  // state handed from cell to cell
  typedef struct packed {
    logic [12:0] w;
    logic [12:0] h;
    logic [11:0] d;
    logic [12:0] pxp;
    logic [12:0] pyp;
    logic [3:0]  n;
    logic [31:0] total;
    logic [13:0] x;
    logic [16:0] y;
    logic [3:0]  qlvl;
    logic [10:0] idx;
    logic        found;
    logic        err;
    logic [12:0] qw;
    logic [12:0] qh;
    logic [11:0] qd;
    logic [12:0] qbx;
    logic [12:0] qby;
    logic [31:0] rbase;
    logic [10:0] ridx;
    logic [12:0] rpitch;
    logic [12:0] cidx;
    logic [12:0] cpitch;
    logic [19:0] stride;
    logic [4:0]  bb;
  } wave_t;

  function automatic logic [12:0] mini13(input logic [12:0] v);
    mini13 = (v[12:1] != '0) ? {1'b0, v[12:1]} : 13'd1;
  endfunction

  function automatic logic [12:0] blocks13(input logic [12:0] v, input logic [1:0] sh);
    logic [13:0] s;
    s = {1'b0, v} + ((14'd1 << sh) - 14'd1);
    blocks13 = 13'(s >> sh);
  endfunction

endpackage

// ----- sv/mlo_cell.sv -----
// ----------------------------------------------------------------------------
// mlo_cell
// One mip level of the layout walk: place the level, capture the query hit,
// minify and hand the state on to the next level.
// ----------------------------------------------------------------------------
module mlo_cell import mlo_pkg::*; #(
  parameter int unsigned LEVEL = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cfg_t cfg_i,
  input  logic      valid_i,
  input  wave_t     wave_i,
  output logic      valid_o,
  output wave_t     wave_o
);

  localparam logic [3:0] Lvl = 4'(LEVEL);

  logic        valid_q;
  wave_t       wave_q, wave_d;
  logic        hit, active;
  logic [12:0] nbx, nbyr, nby, wn, hn, aw;
  logic [11:0] dn, nr;
  logic [12:0] mask13, ncols;
  logic [16:0] ybot;
  logic [13:0] xadd;
  logic [25:0] rows_add;

  always_comb begin
    wave_d   = wave_i;
    active   = (Lvl <= cfg_i.last);
    hit      = active && (wave_i.qlvl == Lvl);
    nbx      = blocks13(wave_i.w, cfg_i.blk_sh);
    nbyr     = blocks13(wave_i.h, cfg_i.blk_sh);
    nby      = 13'(({1'b0, nbyr} + 14'd3) & ~14'd3);
    wn       = mini13(wave_i.w);
    hn       = mini13(wave_i.h);
    dn       = (wave_i.d[11:1] != '0) ? {1'b0, wave_i.d[11:1]} : 12'd1;
    aw       = 13'(({1'b0, wn} + 14'd3) & ~14'd3);
    nr       = cfg_i.volume ? wave_i.d : {8'd0, CUBE_FACES};
    mask13   = (13'd1 << wave_i.n) - 13'd1;
    ncols    = 13'(({1'b0, nr} + mask13) >> wave_i.n);
    rows_add = ncols * wave_i.pyp;
    ybot     = wave_i.y + {4'd0, nby};
    xadd     = 14'(({1'b0, nbx} + 14'd1) & ~14'd1);
    if (active) begin
      if (cfg_i.packed_mode) begin
        if (hit) begin
          wave_d.found = 1'b1;
          wave_d.qw    = wave_i.w;
          wave_d.qh    = wave_i.h;
          wave_d.qd    = wave_i.d;
          wave_d.qbx   = nbx;
          wave_d.qby   = nbyr;
          if ({1'b0, wave_i.idx} < nr) begin
            wave_d.rbase  = wave_i.total;
            wave_d.ridx   = wave_i.idx >> wave_i.n;
            wave_d.rpitch = wave_i.pyp;
            wave_d.cidx   = {2'd0, wave_i.idx & mask13[10:0]};
            wave_d.cpitch = wave_i.pxp;
          end else begin
            wave_d.err = 1'b1;
          end
        end
        wave_d.total = wave_i.total + {6'd0, rows_add};
        if (cfg_i.compressed) begin
          wave_d.pyp = 13'(({1'b0, hn} + 14'd3) >> 2);
          if (wave_i.pxp > aw) begin
            wave_d.pxp = aw;
            wave_d.n   = wave_i.n + 4'd1;
          end
        end else begin
          if (wave_i.pxp > 13'd4) begin
            wave_d.pxp = wave_i.pxp >> 1;
            wave_d.n   = wave_i.n + 4'd1;
          end
          if (wave_i.pyp > 13'd2) begin
            wave_d.pyp = ((wave_i.pyp >> 1) + 13'd1) & ~13'd1;
          end
        end
      end else begin
        if (hit) begin
          wave_d.found = 1'b1;
          wave_d.qw    = wave_i.w;
          wave_d.qh    = wave_i.h;
          wave_d.qd    = 12'd1;
          wave_d.qbx   = nbx;
          wave_d.qby   = nbyr;
          if (wave_i.idx == '0) begin
            wave_d.rbase  = {15'd0, wave_i.y};
            wave_d.ridx   = '0;
            wave_d.rpitch = '0;
            wave_d.cidx   = wave_i.x[12:0];
            wave_d.cpitch = 13'd1;
          end else begin
            wave_d.err = 1'b1;
          end
        end
        if ({15'd0, ybot} > wave_i.total) wave_d.total = {15'd0, ybot};
        if (Lvl == 4'd1) wave_d.x = wave_i.x + xadd;
        else             wave_d.y = ybot;
      end
      wave_d.w = wn;
      wave_d.h = hn;
      wave_d.d = dn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) wave_q <= wave_d;
  end

  assign valid_o = valid_q;
  assign wave_o  = wave_q;

endmodule

// ----- sv/mlo_final.sv -----
// ----------------------------------------------------------------------------
// mlo_final
// Turn the captured row and column counts into a byte offset over two stages
// and pack the result item.
// ----------------------------------------------------------------------------
module mlo_final import mlo_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  wave_t   wave_i,
  output logic    busy_o,
  output logic    done_o,
  output result_t result_o
);

  logic        a_valid_q, b_valid_q;
  wave_t       a_wave_q;
  logic [31:0] a_rows_q;
  logic [25:0] a_cols_q;
  logic [31:0] offset_d;
  logic        err;
  result_t     res_q, res_d;

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      a_wave_q <= wave_i;
      a_rows_q <= wave_i.rbase + {8'd0, 24'(wave_i.ridx) * 24'(wave_i.rpitch)};
      a_cols_q <= wave_i.cidx * wave_i.cpitch;
    end
    if (a_valid_q) res_q <= res_d;
  end

  always_comb begin
    err      = a_wave_q.err || !a_wave_q.found;
    offset_d = 32'(a_rows_q * {12'd0, a_wave_q.stride}) + {1'b0, a_cols_q * a_wave_q.bb};
    res_d.row_stride_bytes = a_wave_q.stride[16:0];
    res_d.total_block_rows = a_wave_q.total[15:0];
    res_d.query_error      = err;
    if (err) begin
      res_d.byte_offset    = '0;
      res_d.level_width    = '0;
      res_d.level_height   = '0;
      res_d.level_depth    = '0;
      res_d.level_blocks_x = '0;
      res_d.level_blocks_y = '0;
    end else begin
      res_d.byte_offset    = offset_d;
      res_d.level_width    = a_wave_q.qw;
      res_d.level_height   = a_wave_q.qh;
      res_d.level_depth    = a_wave_q.qd;
      res_d.level_blocks_x = a_wave_q.qbx;
      res_d.level_blocks_y = a_wave_q.qby;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  assign busy_o   = a_valid_q || b_valid_q;
  assign done_o   = b_valid_q;
  assign result_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.query_error |-> result_o.byte_offset == '0)
    else $error("flagged item carries an offset");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |=> ##1 done_o)
    else $error("offset stage lost an item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(a_valid_q && b_valid_q))
    else $error("two items in the offset stages");

endmodule

// ----- sv/mipmap_layout_offset_calc.sv -----
// ----------------------------------------------------------------------------
// mipmap_layout_offset_calc
// Places one image of a mipmap tree: byte offset, level sizes, row stride and
// total block rows of the tree described by the configuration registers.
// ----------------------------------------------------------------------------
// Usage: write the texture description through cfg_we_i/cfg_idx_i/cfg_data_i
// while busy_o is low. Raise start_i with query_i; the item is taken at a
// clock edge where busy_o is low. busy_o stays high until the result item is
// shown: done_o pulses for one cycle with result_o valid during that cycle.
// The receiver cannot stall; the result must be taken when done_o is high.
// Between the accepting edge and done_o the item passes the seed register,
// one cell per mip level in the chain, and the offset stages that form the
// byte offset. One item is in flight at a time, so a new item can be taken
// the cycle after done_o. Levels above the last present one pass through
// their cell unchanged.
// Reset clears the pipeline and loads the registers with a 1x1x1 2D texture,
// one level, 4-byte uncompressed blocks.
// ----------------------------------------------------------------------------
module mipmap_layout_offset_calc import mlo_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start_i,
  input  query_t              query_i,
  output logic                busy_o,
  output logic                done_o,
  output result_t             result_o
);

  localparam logic [14:0] DimMax   = 15'(MaxDim);
  localparam logic [14:0] DepthMax = 15'(MaxDim / 2);
  localparam logic [3:0]  LastMax  = 4'(MAX_LEVELS - 1);

  logic [1:0]  target_q;
  logic        comp_q;
  logic [12:0] bw_q, bh_q;
  logic [11:0] bd_q;
  logic [3:0]  fl_q;
  logic [4:0]  bb_q;
  logic [1:0]  bdim_q;

  cell_cfg_t   ccfg;
  logic [12:0] w0, h0, nbx0, nby0, m1;
  logic [11:0] d0;
  logic [19:0] s1, stride0;
  wave_t       seed_d, seed_q;
  logic        seed_valid_q;
  logic        accept, fin_busy;

  logic  [MAX_LEVELS:0] cv;
  wave_t [MAX_LEVELS:0] cw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      comp_q   <= 1'b0;
      bw_q     <= 13'd1;
      bh_q     <= 13'd1;
      bd_q     <= 12'd1;
      fl_q     <= '0;
      bb_q     <= 5'd4;
      bdim_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TARGET_MODE: target_q <= cfg_data_i[1:0];
        REG_COMPRESSED:  comp_q   <= cfg_data_i[0];
        REG_BASE_WIDTH:  bw_q     <= cfg_data_i;
        REG_BASE_HEIGHT: bh_q     <= cfg_data_i;
        REG_BASE_DEPTH:  bd_q     <= cfg_data_i[11:0];
        REG_FINAL_LEVEL: fl_q     <= cfg_data_i[3:0];
        REG_BLOCK_BYTES: bb_q     <= cfg_data_i[4:0];
        REG_BLOCK_DIM:   bdim_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ccfg.packed_mode = (target_q == TARGET_CUBE) || (target_q == TARGET_VOLUME);
    ccfg.volume      = (target_q == TARGET_VOLUME);
    ccfg.compressed  = comp_q;
    ccfg.blk_sh      = bdim_q;
    ccfg.last        = (fl_q > LastMax) ? LastMax : fl_q;

    // clamp base size, zero reads as one
    w0 = (bw_q == '0) ? 13'd1 : (({2'd0, bw_q} > DimMax) ? DimMax[12:0] : bw_q);
    h0 = (bh_q == '0) ? 13'd1 : (({2'd0, bh_q} > DimMax) ? DimMax[12:0] : bh_q);
    d0 = (bd_q == '0) ? 12'd1 : (({3'd0, bd_q} > DepthMax) ? DepthMax[11:0] : bd_q);
    nbx0 = blocks13(w0, bdim_q);
    nby0 = blocks13(h0, bdim_q);

    seed_d        = '0;
    seed_d.w      = w0;
    seed_d.h      = h0;
    seed_d.d      = d0;
    seed_d.qlvl   = query_i.query_level;
    seed_d.idx    = query_i.image_index;
    seed_d.bb     = bb_q;
    seed_d.pxp    = 13'(({1'b0, nbx0} + 14'd3) & ~14'd3);
    seed_d.pyp    = 13'(({1'b0, nby0} + 14'd1) & ~14'd1);

    // 2D stride: widen for levels one and two side by side
    m1 = 13'(({1'b0, blocks13(mini13(w0), bdim_q)} + 14'd1) & ~14'd1)
         + blocks13(mini13(mini13(w0)), bdim_q);
    s1 = ({7'd0, nbx0} * {15'd0, bb_q} + 20'd3) & ~20'd3;
    if ((ccfg.last != '0) && (m1 > nbx0)) s1 = {7'd0, m1} * {15'd0, bb_q};
    stride0 = (s1 + 20'd63) & ~20'd63;

    seed_d.stride = ccfg.packed_mode ? {7'd0, seed_d.pxp} * {15'd0, bb_q} : stride0;
  end

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_valid_q <= 1'b0;
    end else begin
      seed_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) seed_q <= seed_d;
  end

  assign cv[0] = seed_valid_q;
  assign cw[0] = seed_q;

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
    mlo_cell #(.LEVEL(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (ccfg),
      .valid_i (cv[k]),
      .wave_i  (cw[k]),
      .valid_o (cv[k+1]),
      .wave_o  (cw[k+1])
    );
  end

  mlo_final u_final (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cv[MAX_LEVELS]),
    .wave_i   (cw[MAX_LEVELS]),
    .busy_o   (fin_busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  assign busy_o = (|cv) || fin_busy;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cv, fin_busy}))
    else $error("more than one item in the level chain");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> seed_valid_q && busy_o)
    else $error("accepted item did not enter the chain");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(|cv))
    else $error("result shown while an item still walks the levels");

endmodule
